FILE: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared width constants and request/result types for the modular
// exponentiation block and its bit-serial modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // operand width of base, exponent, modulus and result
  localparam int unsigned MexpWidth = 32;
  // bit counter width for one serial multiply
  localparam int unsigned MexpCntW = $clog2(MexpWidth);

  // input request
  typedef struct packed {
    logic [MexpWidth-1:0] base;
    logic [MexpWidth-1:0] exponent;
    logic [MexpWidth-1:0] modulus;
  } mexp_in_t;

  // output result
  typedef struct packed {
    logic [MexpWidth-1:0] power_mod;
    logic                 bad_modulus;
  } mexp_out_t;

  // start of one modular multiply: a * b mod n, with a < n and n != 0
  typedef struct packed {
    logic                 start;
    logic [MexpWidth-1:0] a;
    logic [MexpWidth-1:0] b;
    logic [MexpWidth-1:0] n;
  } mexp_mm_req_t;

  // completion of one modular multiply
  typedef struct packed {
    logic                 done;
    logic [MexpWidth-1:0] prod;
  } mexp_mm_rsp_t;

endpackage

FILE: design/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: scans b from its top bit down, one bit per
// cycle, doubling the accumulator, adding a on set bits, reducing modulo n.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mexp_pkg::mexp_mm_req_t req_i,
  output mexp_pkg::mexp_mm_rsp_t rsp_o
);
  import mexp_pkg::*;

  localparam int unsigned SumW = MexpWidth + 2;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MexpCntW-1:0]  cnt_q, cnt_d;
  logic [MexpWidth-1:0] acc_q, acc_d;
  logic [MexpWidth-1:0] a_q, a_d;
  logic [MexpWidth-1:0] b_q, b_d;
  logic [MexpWidth-1:0] n_q, n_d;

  logic [SumW-1:0] sum;
  logic [SumW-1:0] n_one;
  logic [SumW-1:0] n_two;
  logic [SumW-1:0] diff_one;
  logic [SumW-1:0] diff_two;
  logic [MexpWidth-1:0] acc_step;

  // one step: 2*acc + bit*a stays below 3n, so at most 2n comes off
  always_comb begin
    sum      = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[MexpWidth-1] ? a_q : '0)};
    n_one    = {2'b00, n_q};
    n_two    = {1'b0, n_q, 1'b0};
    diff_one = sum - n_one;
    diff_two = sum - n_two;
    if (sum >= n_two) begin
      acc_step = diff_two[MexpWidth-1:0];
    end else if (sum >= n_one) begin
      acc_step = diff_one[MexpWidth-1:0];
    end else begin
      acc_step = sum[MexpWidth-1:0];
    end
  end

  // sequencing of one multiply
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    n_d    = n_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = MexpCntW'(MexpWidth - 1);
      acc_d  = '0;
      a_d    = req_i.a;
      b_d    = req_i.b;
      n_d    = req_i.n;
    end else if (busy_q) begin
      acc_d = acc_step;
      b_d   = {b_q[MexpWidth-2:0], 1'b0};
      cnt_d = cnt_q - MexpCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and accumulator shift registers
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    n_q   <= n_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

`ifndef NO_ASSERTIONS
  // a new multiply never lands on one still running
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("mulmod started while busy");

  // accumulator stays reduced throughout
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> (acc_q < n_q))
    else $error("mulmod accumulator not reduced");

  // completion is a single-cycle pulse after the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q && !$past(done_q))
    else $error("mulmod done not a clean pulse");
`endif

endmodule

FILE: design/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left square-and-multiply modular exponentiation.
// ----------------------------------------------------------------------------
// One request at a time: base^exponent mod modulus. The base is first reduced
// by one serial multiply, then each exponent bit costs a square, plus a
// multiply when the bit is set, on the single shared bit-serial multiplier,
// with a decision state (S_ROUND) ahead of each bit. The scan stops once the
// remaining exponent bits are all zero. A zero modulus raises bad_modulus with
// a zero result. The finished result sits in an output register, so the next
// request is taken while it waits to be collected.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mexp_pkg::mexp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mexp_pkg::mexp_out_t out_data_o
);
  import mexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_ROUND  = 6'b000100,
    S_MUL    = 6'b001000,
    S_SQR    = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [MexpWidth-1:0] acc_q, acc_d;
  logic [MexpWidth-1:0] sq_q, sq_d;
  logic [MexpWidth-1:0] exp_q, exp_d;
  logic [MexpWidth-1:0] n_q, n_d;
  logic                 bad_q, bad_d;

  logic      out_valid_q, out_valid_d;
  mexp_out_t out_data_q, out_data_d;

  logic         in_take;
  logic         out_free;
  mexp_mm_req_t mm_req;
  mexp_mm_rsp_t mm_rsp;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared serial multiplier
  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

  // square-and-multiply sequencer
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    exp_d       = exp_q;
    n_d         = n_q;
    bad_d       = bad_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mm_req      = '0;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          exp_d = in_data_i.exponent;
          n_d   = in_data_i.modulus;
          if (in_data_i.modulus == '0) begin
            acc_d   = '0;
            bad_d   = 1'b1;
            state_d = S_DONE;
          end else begin
            // base mod n as (1 mod n) * base mod n
            acc_d     = MexpWidth'(in_data_i.modulus != MexpWidth'(1));
            bad_d     = 1'b0;
            mm_req.start = 1'b1;
            mm_req.a     = MexpWidth'(in_data_i.modulus != MexpWidth'(1));
            mm_req.b     = in_data_i.base;
            mm_req.n     = in_data_i.modulus;
            state_d   = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (mm_rsp.done) begin
          sq_d    = mm_rsp.prod;
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        mm_req.n = n_q;
        if (exp_q == '0) begin
          state_d = S_DONE;
        end else if (exp_q[0]) begin
          mm_req.start = 1'b1;
          mm_req.a     = acc_q;
          mm_req.b     = sq_q;
          state_d      = S_MUL;
        end else begin
          mm_req.start = 1'b1;
          mm_req.a     = sq_q;
          mm_req.b     = sq_q;
          state_d      = S_SQR;
        end
      end
      S_MUL: begin
        mm_req.n = n_q;
        if (mm_rsp.done) begin
          acc_d        = mm_rsp.prod;
          mm_req.start = 1'b1;
          mm_req.a     = sq_q;
          mm_req.b     = sq_q;
          state_d      = S_SQR;
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          sq_d    = mm_rsp.prod;
          exp_d   = {1'b0, exp_q[MexpWidth-1:1]};
          state_d = S_ROUND;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.power_mod   = acc_q;
          out_data_d.bad_modulus = bad_q;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers and output payload
  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    sq_q       <= sq_d;
    exp_q      <= exp_d;
    n_q        <= n_d;
    bad_q      <= bad_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // a zero modulus goes straight to the result with the error flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (in_data_i.modulus == '0) |=> (state_q == S_DONE) && bad_q)
    else $error("zero modulus not flagged");

  // running result and square stay reduced between rounds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND) |-> (acc_q < n_q) && (sq_q < n_q))
    else $error("operands not reduced at round start");

  // the multiplier only finishes while a multiply is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_rsp.done |-> (state_q == S_REDUCE) || (state_q == S_MUL) || (state_q == S_SQR))
    else $error("unexpected multiplier completion");

  // a finished request is handed over only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (state_d == S_IDLE) |=> out_valid_q)
    else $error("result not presented");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the modular exponentiation block. A short table of
// directed requests (zero and unit moduli, zero exponents, full-width
// operands) is followed by random requests with mostly short exponents. Each
// result is compared field by field, in request order, under random idling
// on both channels, to a typed value or a double-width software predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mexp_pkg::*;

  localparam int unsigned RandomItems = 272;
  localparam int unsigned TailItems   = 40;
  localparam int unsigned MidPause    = 130;
  localparam int unsigned DrainCycles = 2300;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned NumRows     = 18;
  localparam bit          Typed       = 1'b1;
  localparam bit          Predicted   = 1'b0;

  // one row of the directed table
  typedef struct packed {
    mexp_in_t  req;
    logic      typed;
    mexp_out_t want;
  } vector_row_t;

  localparam vector_row_t DirectedRows[NumRows] = '{
    '{'{32'h0, 32'h0, 32'h0}, Typed, '{32'h0, 1'b1}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0}, Typed, '{32'h0, 1'b1}},
    '{'{32'd5, 32'd0, 32'd7}, Typed, '{32'd1, 1'b0}},
    '{'{32'd0, 32'd0, 32'd1}, Typed, '{32'd0, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1}, Typed, '{32'd0, 1'b0}},
    '{'{32'd0, 32'd0, 32'd13}, Typed, '{32'd1, 1'b0}},
    '{'{32'd0, 32'd5, 32'd13}, Typed, '{32'd0, 1'b0}},
    '{'{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, Typed, '{32'd1, 1'b0}},
    '{'{32'd2, 32'd10, 32'd1000}, Typed, '{32'd24, 1'b0}},
    '{'{32'd3, 32'd4, 32'd100}, Typed, '{32'd81, 1'b0}},
    '{'{32'd10, 32'd2, 32'd7}, Typed, '{32'd2, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}, Typed, '{32'd0, 1'b0}},
    '{'{32'd7, 32'd1, 32'd2}, Typed, '{32'd1, 1'b0}},
    '{'{32'd2, 32'hFFFF_FFFF, 32'h8000_0000}, Typed, '{32'd0, 1'b0}},
    '{'{32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, Predicted, '{32'd0, 1'b0}},
    '{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFB}, Predicted, '{32'd0, 1'b0}},
    '{'{32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFB}, Predicted, '{32'd0, 1'b0}},
    '{'{32'h9E37_79B9, 32'h7FFF_FFFF, 32'h8000_0001}, Predicted, '{32'd0, 1'b0}}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  mexp_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  mexp_out_t out_data_o;

  mexp_out_t   pending_powers[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          quiet_tail     = 1'b0;
  bit          stall_mode     = 1'b1;
  int unsigned stall_left     = 0;

  modular_exponentiation_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // base^exponent mod modulus with double-width products
  function automatic mexp_out_t predict_power_mod(mexp_in_t req);
    logic [2*MexpWidth-1:0] n;
    logic [2*MexpWidth-1:0] sq;
    logic [2*MexpWidth-1:0] acc;
    logic [MexpWidth-1:0]   bits;
    mexp_out_t              res;
    res = '0;
    if (req.modulus == '0) begin
      res.bad_modulus = 1'b1;
      return res;
    end
    n    = req.modulus;
    acc  = 1 % n;
    sq   = req.base % n;
    bits = req.exponent;
    while (bits != '0) begin
      if (bits[0]) acc = (acc * sq) % n;
      sq   = (sq * sq) % n;
      bits = bits >> 1;
    end
    res.power_mod = acc[MexpWidth-1:0];
    return res;
  endfunction

  // random request, biased to short exponents and awkward moduli
  function automatic mexp_in_t random_request();
    mexp_in_t               req;
    int unsigned            pick;
    int unsigned            len;
    logic [2*MexpWidth-1:0] mask;
    pick = $urandom_range(0, 99);
    if (pick < 4)       req.modulus = '0;
    else if (pick < 8)  req.modulus = 1;
    else if (pick < 16) req.modulus = $urandom_range(2, 16);
    else if (pick < 26) req.modulus = '1 - $urandom_range(0, 64);
    else                req.modulus = $urandom();

    pick = $urandom_range(0, 99);
    if (pick < 10)      req.base = '0;
    else if (pick < 15) req.base = 1;
    else if (pick < 25) req.base = '1;
    else if (pick < 45 && req.modulus != '0) req.base = $urandom_range(0, req.modulus - 1);
    else                req.base = $urandom();

    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req.exponent = '0;
    end else if (pick < 90) begin
      len  = (pick < 62) ? $urandom_range(1, 12) : $urandom_range(13, MexpWidth);
      mask = ({{MexpWidth{1'b0}}, {MexpWidth{1'b1}}} >> (MexpWidth - len));
      req.exponent = $urandom() & mask[MexpWidth-1:0];
    end else begin
      req.exponent = $urandom();
    end
    return req;
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(input mexp_in_t req, input mexp_out_t want);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pending_powers.push_back(want);
  endtask

  // optional idle burst on the request side
  task automatic request_gap();
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // hold off until every outstanding result has been collected
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk_i);
  endtask

  // result side stall bursts, alternating busy and calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
      stall_mode  <= 1'b1;
    end else begin
      if ($urandom_range(0, 399) == 0) stall_mode <= !stall_mode;
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && stall_mode && $urandom_range(0, 3) == 0) begin
        stall_left  <= $urandom_range(0, 13);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    mexp_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_powers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got power_mod %h bad_modulus %b",
                 $time, out_data_o.power_mod, out_data_o.bad_modulus);
        mismatch_count++;
      end else begin
        want = pending_powers.pop_front();
        if (out_data_o.power_mod !== want.power_mod) begin
          $display("%0t: power_mod mismatch, expected %h, got %h",
                   $time, want.power_mod, out_data_o.power_mod);
          mismatch_count++;
        end
        if (out_data_o.bad_modulus !== want.bad_modulus) begin
          $display("%0t: bad_modulus mismatch, expected %b, got %b",
                   $time, want.bad_modulus, out_data_o.bad_modulus);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    mexp_in_t req;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int unsigned row = 0; row < NumRows; row++) begin
      request_gap();
      send_request(DirectedRows[row].req,
                   DirectedRows[row].typed ? DirectedRows[row].want
                                           : predict_power_mod(DirectedRows[row].req));
    end
    drain_results();

    // random requests, quiet tail at the end
    for (int unsigned idx = 0; idx < RandomItems; idx++) begin
      if (idx == MidPause) drain_results();
      if (idx == RandomItems - TailItems) quiet_tail <= 1'b1;
      request_gap();
      req = random_request();
      send_request(req, predict_power_mod(req));
    end
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: modular_exponentiation_top.f
design/mexp_pkg.sv
design/mexp_mulmod.sv
design/modular_exponentiation_top.sv
tb/tb_top.sv
